[rtl/hid_keyboard_report_parser_macros.svh]
// ----------------------------------------------------------------------------
// hid_keyboard_report_parser_macros
// Assertion helpers used by the emitter of the keyboard report parser.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_PARSER_MACROS_SVH
`define HID_KEYBOARD_REPORT_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, muted during reset.
`define HKP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted during reset.
`define HKP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/hkp_pkg.sv]
// ----------------------------------------------------------------------------
// hkp_pkg
// Types and constants shared by the keyboard report parser modules.
// ----------------------------------------------------------------------------
package hkp_pkg;

	localparam int MAX_KEYS_DEF = 6;
	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 6;
	localparam int BOOT_LEN     = 8;
	localparam int ID_LEN       = 9;
	localparam int BOOT_KEYS    = 6;
	localparam int BOOT_FIRST   = 2;
	localparam int ID_FIRST     = 3;
	localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_REPORT_MODE = 1'b0;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_report;
	} byte_item_t;

	typedef struct packed {
		logic              accepted;
		logic              has_id;
		logic [BYTE_W-1:0] id_value;
		logic [BYTE_W-1:0] modifier_bits;
		logic [BYTE_W-1:0] key_code;
		logic [CNT_W-1:0]  pressed_count;
		logic              final_item;
	} key_item_t;

	// decoded report layout, handed from the decoder to the emitter
	typedef struct packed {
		logic              short_rpt;
		logic              has_id;
		logic [BYTE_W-1:0] id_value;
		logic [BYTE_W-1:0] mods;
		logic [1:0]        first;
		logic [CNT_W-1:0]  nkeys;
	} layout_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_READ,
		EM_DATA,
		EM_SUM
	} em_state_t;

endpackage

[rtl/hkp_byte_ram.sv]
// ----------------------------------------------------------------------------
// hkp_byte_ram
// Report byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hkp_byte_ram
	import hkp_pkg::*;
#(
	parameter int DEPTH = MAX_KEYS_DEF + 3,
	parameter int AW    = $clog2(MAX_KEYS_DEF + 3)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/hkp_layout.sv]
// ----------------------------------------------------------------------------
// hkp_layout
// Picks modifier byte, report id and key byte window from the report head.
// ----------------------------------------------------------------------------
module hkp_layout
	import hkp_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic              report_mode,
	input  logic [BYTE_W-1:0] len,
	input  logic [BYTE_W-1:0] b0,
	input  logic [BYTE_W-1:0] b1,
	input  logic [BYTE_W-1:0] b2,
	output layout_t           lay
);

	logic              id_ok;
	logic              boot;
	logic [BYTE_W-1:0] lm2;
	logic [BYTE_W-1:0] nk;

	always_comb begin
		id_ok = report_mode && (len >= BYTE_W'(ID_LEN)) && (b1 != '0) && (b2 == '0);
		boot  = !report_mode || (b1 == '0);
		lm2   = len - BYTE_W'(BOOT_FIRST);
		nk    = (lm2 > BYTE_W'(MAX_KEYS)) ? BYTE_W'(MAX_KEYS) : lm2;

		lay           = '0;
		lay.short_rpt = len < BYTE_W'(BOOT_LEN);
		if (!lay.short_rpt) begin
			if (id_ok) begin
				lay.has_id   = 1'b1;
				lay.id_value = b0;
				lay.mods     = b1;
				lay.first    = 2'(ID_FIRST);
				lay.nkeys    = CNT_W'(BOOT_KEYS);
			end else if (boot) begin
				lay.mods  = b0;
				lay.first = 2'(BOOT_FIRST);
				lay.nkeys = CNT_W'(BOOT_KEYS);
			end else begin
				lay.mods  = b0;
				lay.first = 2'(BOOT_FIRST);
				lay.nkeys = nk[CNT_W-1:0];
			end
		end
	end

endmodule

[rtl/hkp_emitter.sv]
// ----------------------------------------------------------------------------
// hkp_emitter
// Walks the key window of the byte store and emits key words and a summary.
// ----------------------------------------------------------------------------
module hkp_emitter
	import hkp_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  layout_t                             lay,
	output logic                                rd_en,
	output logic [$clog2(MAX_KEYS + 3)-1:0]     rd_addr,
	input  logic [BYTE_W-1:0]                   rd_data,
	output logic                                busy,
	output logic                                out_valid,
	input  logic                                out_ready,
	output key_item_t                           out_data
);

`include "hid_keyboard_report_parser_macros.svh"

	localparam int AW = $clog2(MAX_KEYS + 3);

	em_state_t         state_q;
	em_state_t         state_nxt;
	layout_t           lay_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	key_item_t         out_q;
	logic              slot_free;
	logic              last_key;
	logic              advance;
	logic              load_key;
	logic              load_sum;
	logic [BYTE_W-1:0] addr_sum;

	assign slot_free = !out_valid_q || out_ready;
	assign last_key  = (idx_q + CNT_W'(1)) == lay_q.nkeys;
	assign advance   = (rd_data == '0) || slot_free;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			EM_IDLE: begin
				if (start) begin
					state_nxt = lay.short_rpt ? EM_SUM : EM_READ;
				end
			end
			EM_READ: state_nxt = EM_DATA;
			EM_DATA: begin
				if (advance) begin
					state_nxt = last_key ? EM_SUM : EM_READ;
				end
			end
			EM_SUM: begin
				if (slot_free) begin
					state_nxt = EM_IDLE;
				end
			end
			default: state_nxt = EM_IDLE;
		endcase
	end

	always_comb begin
		addr_sum = BYTE_W'(lay_q.first) + BYTE_W'(idx_q);
		rd_addr  = addr_sum[AW-1:0];
		rd_en    = state_q == EM_READ;
		busy     = state_q != EM_IDLE;
		load_key = (state_q == EM_DATA) && (rd_data != '0) && slot_free;
		load_sum = (state_q == EM_SUM) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EM_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == EM_IDLE && start) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (state_q == EM_DATA && advance) begin
				idx_q <= idx_q + CNT_W'(1);
				if (load_key) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (load_key || load_sum) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EM_IDLE && start) begin
			lay_q <= lay;
		end
		if (load_key) begin
			out_q.accepted      <= 1'b1;
			out_q.has_id        <= lay_q.has_id;
			out_q.id_value      <= lay_q.id_value;
			out_q.modifier_bits <= lay_q.mods;
			out_q.key_code      <= rd_data;
			out_q.pressed_count <= '0;
			out_q.final_item    <= 1'b0;
		end else if (load_sum) begin
			out_q.accepted      <= !lay_q.short_rpt;
			out_q.has_id        <= lay_q.has_id;
			out_q.id_value      <= lay_q.id_value;
			out_q.modifier_bits <= lay_q.mods;
			out_q.key_code      <= '0;
			out_q.pressed_count <= cnt_q;
			out_q.final_item    <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`HKP_ASSERT_NOW(a_key_from_good_rpt, out_valid_q && !out_q.final_item, out_q.accepted, "key word from rejected report")
	`HKP_ASSERT_NOW(a_key_nonzero, out_valid_q && !out_q.final_item, out_q.key_code != '0, "zero key code emitted")
	`HKP_ASSERT_NOW(a_short_clean, out_valid_q && out_q.final_item && !out_q.accepted, (out_q.key_code == '0) && (out_q.pressed_count == '0) && !out_q.has_id, "failure word not clean")
	`HKP_ASSERT_NEXT(a_read_then_data, state_q == EM_READ, state_q == EM_DATA, "store read not followed by data step")

endmodule

[rtl/hid_keyboard_report_parser.sv]
// ----------------------------------------------------------------------------
// hid_keyboard_report_parser
// USB boot keyboard report parser with report id detection.
// ----------------------------------------------------------------------------
// Report bytes are taken one per cycle while the block is not busy; the first MAX_KEYS + 3 bytes
// of a report are written to the byte store as they arrive. After the last byte, input stalls
// while the key bytes are examined (6, or up to MAX_KEYS), each with a store read and a check;
// a short report goes straight to the summary word. A word held on the output prolongs the stall.
// Reset clears byte count, report_mode and control state; store contents stay
// undefined until written.
module hid_keyboard_report_parser
	import hkp_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  byte_item_t         byte_item,
	output logic               key_valid,
	input  logic               key_ready,
	output key_item_t          key_item
);

	localparam int STORE_DEPTH = MAX_KEYS + 3;
	localparam int AW          = $clog2(STORE_DEPTH);

	logic              report_mode_q;
	logic [BYTE_W-1:0] count_q;
	logic [BYTE_W-1:0] count_nxt;
	logic [BYTE_W-1:0] len_q;
	logic [BYTE_W-1:0] b0_q;
	logic [BYTE_W-1:0] b1_q;
	logic [BYTE_W-1:0] b2_q;
	logic              done_q;
	logic              accept;
	logic              wr_en;
	logic              busy;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;
	layout_t           lay;

	assign pready = 1'b1;
	assign prdata = PDATA_W'(report_mode_q);

	assign byte_ready = !done_q && !busy;
	assign accept     = byte_valid && byte_ready;
	assign count_nxt  = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + BYTE_W'(1);
	assign wr_en      = accept && (count_q < BYTE_W'(STORE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_mode_q <= 1'b0;
			count_q       <= '0;
			done_q        <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_REPORT_MODE) begin
				report_mode_q <= pwdata[0];
			end
			done_q <= accept && byte_item.end_of_report;
			if (accept) begin
				count_q <= byte_item.end_of_report ? '0 : count_nxt;
			end
		end
	end

	// head bytes kept in flops so the layout decode sees them together
	always_ff @(posedge clk) begin
		if (accept) begin
			if (count_q == BYTE_W'(0)) begin
				b0_q <= byte_item.data_byte;
			end
			if (count_q == BYTE_W'(1)) begin
				b1_q <= byte_item.data_byte;
			end
			if (count_q == BYTE_W'(2)) begin
				b2_q <= byte_item.data_byte;
			end
			if (byte_item.end_of_report) begin
				len_q <= count_nxt;
			end
		end
	end

	hkp_byte_ram #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (byte_item.data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	hkp_layout #(
		.MAX_KEYS (MAX_KEYS)
	) u_layout (
		.report_mode (report_mode_q),
		.len         (len_q),
		.b0          (b0_q),
		.b1          (b1_q),
		.b2          (b2_q),
		.lay         (lay)
	);

	hkp_emitter #(
		.MAX_KEYS (MAX_KEYS)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (done_q),
		.lay       (lay),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.busy      (busy),
		.out_valid (key_valid),
		.out_ready (key_ready),
		.out_data  (key_item)
	);

endmodule

[tb/sv/hid_keyboard_report_parser_tb.sv]
// ----------------------------------------------------------------------------
// hid_keyboard_report_parser_tb
// Drives keyboard reports byte by byte in both protocol modes and checks
// every key and summary word against a built-in parser model.
// ----------------------------------------------------------------------------
module hid_keyboard_report_parser_tb;
	import hkp_pkg::*;

	localparam int KEY_LIMIT   = MAX_KEYS_DEF;
	localparam int STORE_DEPTH = KEY_LIMIT + 3;
	localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * REG_REPORT_MODE);
	localparam int RANDOM_BYTES = 140;
	localparam int PHASES       = 4;
	localparam int GAP_PCT      = 33;
	// sender runs without gaps over this byte range, receiver over this word range
	localparam int SEND_RUN_LO  = 340;
	localparam int SEND_RUN_HI  = 430;
	localparam int RECV_RUN_LO  = 50;
	localparam int RECV_RUN_HI  = 90;
	localparam int HOLD_AT      = 30;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;

	class kbd_scoreboard;
		logic              report_mode;
		logic [BYTE_W-1:0] stash [STORE_DEPTH];
		logic [BYTE_W-1:0] fill;
		key_item_t         want_q[$];
		int                errors;
		int                results;
		int                reports;
		int                shorts;
		int                ids;
		int                keys;

		function new();
			report_mode = 1'b0;
			fill        = '0;
			errors      = 0;
			results     = 0;
			reports     = 0;
			shorts      = 0;
			ids         = 0;
			keys        = 0;
		endfunction

		function void fault(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] ERROR: %s", $realtime, msg);
		endfunction

		// one accepted report byte; on the last byte, queue the words the report yields
		function void note_byte(byte_item_t it);
			int                len;
			int                first;
			int                nkeys;
			int                found;
			logic              with_id;
			logic [BYTE_W-1:0] id_byte;
			logic [BYTE_W-1:0] mods;
			key_item_t         r;
			if (fill < STORE_DEPTH)
				stash[fill] = it.data_byte;
			if (fill != COUNT_MAX)
				fill++;
			if (!it.end_of_report)
				return;
			len  = fill;
			fill = '0;
			reports++;
			r = '0;
			if (len < BOOT_LEN) begin
				r.final_item = 1'b1;
				want_q.push_back(r);
				shorts++;
				return;
			end
			with_id = 1'b0;
			id_byte = '0;
			mods    = stash[0];
			first   = BOOT_FIRST;
			nkeys   = BOOT_KEYS;
			if (report_mode && len >= ID_LEN && stash[1] != 0 && stash[2] == 0) begin
				with_id = 1'b1;
				id_byte = stash[0];
				mods    = stash[1];
				first   = ID_FIRST;
				ids++;
			end else if (report_mode && stash[1] != 0) begin
				nkeys = (len - 2 < KEY_LIMIT) ? len - 2 : KEY_LIMIT;
			end
			r.accepted      = 1'b1;
			r.has_id        = with_id;
			r.id_value      = id_byte;
			r.modifier_bits = mods;
			found = 0;
			for (int i = 0; i < nkeys; i++) begin
				if (stash[first + i] != 0) begin
					r.key_code = stash[first + i];
					want_q.push_back(r);
					found++;
				end
			end
			keys += found;
			r.key_code      = '0;
			r.pressed_count = CNT_W'(found);
			r.final_item    = 1'b1;
			want_q.push_back(r);
		endfunction

		function void check_key(key_item_t got);
			key_item_t want;
			results++;
			if (want_q.size() == 0) begin
				fault($sformatf("unexpected word acc=%0d key=%02h fin=%0d",
					got.accepted, got.key_code, got.final_item));
				return;
			end
			want = want_q.pop_front();
			if (got.accepted !== want.accepted || got.has_id !== want.has_id ||
					got.id_value !== want.id_value ||
					got.modifier_bits !== want.modifier_bits ||
					got.key_code !== want.key_code ||
					got.pressed_count !== want.pressed_count ||
					got.final_item !== want.final_item)
				fault($sformatf({"word %0d: expected acc=%0d hid=%0d id=%02h mod=%02h ",
					"key=%02h cnt=%0d fin=%0d, got acc=%0d hid=%0d id=%02h mod=%02h ",
					"key=%02h cnt=%0d fin=%0d"}, results,
					want.accepted, want.has_id, want.id_value, want.modifier_bits,
					want.key_code, want.pressed_count, want.final_item,
					got.accepted, got.has_id, got.id_value, got.modifier_bits,
					got.key_code, got.pressed_count, got.final_item));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               byte_valid;
	logic               byte_ready;
	byte_item_t         byte_item;
	logic               key_valid;
	logic               key_ready;
	key_item_t          key_item;

	kbd_scoreboard      sb;
	logic [BYTE_W-1:0]  report_buf[$];
	int                 sent_total;
	int                 random_sent;
	int                 cycles = 0;
	bit                 held;

	hid_keyboard_report_parser #(
		.MAX_KEYS(KEY_LIMIT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_item   (key_item)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic mode_write(input logic value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODE_ADDR;
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.report_mode = value;
		// read it back
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== PDATA_W'(value))
			sb.fault($sformatf("report_mode read %08h, expected %0d", prdata, value));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_report();
		byte_item_t it;
		for (int i = 0; i < report_buf.size(); i++) begin
			while (!(sent_total >= SEND_RUN_LO && sent_total < SEND_RUN_HI) &&
					$urandom_range(0, 99) < GAP_PCT) begin
				byte_valid <= 1'b0;
				@(posedge clk);
			end
			it.data_byte     = report_buf[i];
			it.end_of_report = (i == report_buf.size() - 1);
			byte_valid <= 1'b1;
			byte_item  <= it;
			@(posedge clk);
			while (!byte_ready) @(posedge clk);
			sb.note_byte(it);
			sent_total++;
		end
	endtask

	// wait until every queued word has come back, then let the block settle
	task automatic drain();
		byte_valid <= 1'b0;
		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [BYTE_W-1:0] key_byte(input int zero_pct);
		if ($urandom_range(0, 99) < zero_pct)
			return '0;
		return BYTE_W'($urandom_range(1, 255));
	endfunction

	task automatic build_random_report();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			len = $urandom_range(1, 7);
		else if (pick < 72)
			len = $urandom_range(8, 9);
		else if (pick < 92)
			len = $urandom_range(10, 16);
		else
			len = $urandom_range(17, 40);
		report_buf.delete();
		for (int i = 0; i < len; i++) begin
			case (i)
				0: report_buf.push_back(BYTE_W'($urandom_range(0, 255)));
				1: report_buf.push_back(key_byte(30));
				2: report_buf.push_back(key_byte(50));
				default: report_buf.push_back(key_byte(30));
			endcase
		end
	endtask

	task automatic directed_reports();
		report_buf = '{8'h55};
		send_report();
		report_buf = '{8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
		send_report();
		// all six keys set, extreme values
		report_buf = '{8'hFF, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h02, 8'h04};
		send_report();
		report_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_report();
		// id-like bytes in boot mode stay in the boot layout
		report_buf = '{8'h01, 8'h02, 8'h00, 8'h04, 8'h05, 8'h00, 8'h06, 8'h07, 8'hFF};
		send_report();
		drain();
		mode_write(1'b1);
		report_buf = '{8'h01, 8'h02, 8'h00, 8'h04, 8'h05, 8'h00, 8'h06, 8'h07, 8'hFF};
		send_report();
		// too short for an id
		report_buf = '{8'h03, 8'h02, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08};
		send_report();
		report_buf = '{8'hAA, 8'h00, 8'h00, 8'h1E, 8'h00, 8'h1F, 8'h20, 8'h21, 8'h22};
		send_report();
		report_buf = '{8'h80, 8'h40, 8'h2C, 8'h00, 8'h2D, 8'h2E, 8'h00, 8'h2F, 8'h30, 8'h31};
		send_report();
		// long report: count saturates, tail never examined
		report_buf = '{8'h07, 8'h02, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
		for (int i = 0; i < 251; i++)
			report_buf.push_back(BYTE_W'($urandom_range(0, 255)));
		send_report();
		drain();
	endtask

	initial begin
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		byte_valid <= 1'b0;
		byte_item  <= '0;
		sent_total = 0;
		random_sent = 0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		mode_write(1'b0);
		directed_reports();
		for (int p = 0; p < PHASES; p++) begin
			mode_write(p[0] ? 1'b0 : 1'b1);
			while (random_sent < (p + 1) * RANDOM_BYTES / PHASES) begin
				build_random_report();
				random_sent += report_buf.size();
				send_report();
			end
			drain();
		end
		$display("%0d reports (%0d short, %0d with id), %0d bytes in both modes",
			sb.reports, sb.shorts, sb.ids, sent_total);
		$display("%0d words checked, %0d of them keys, one long output stall",
			sb.results, sb.keys);
		if (sb.errors == 0 && sb.want_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		key_ready <= 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (sb.results == HOLD_AT && !held) begin
				// hold the output long enough for the block to back up its input
				held = 1'b1;
				key_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				key_ready <= (sb.results >= RECV_RUN_LO && sb.results < RECV_RUN_HI) ||
					$urandom_range(0, 99) >= GAP_PCT;
				@(posedge clk);
				if (key_valid && key_ready)
					sb.check_key(key_item);
			end
		end
	end

endmodule

[hid_keyboard_report_parser.f]
+incdir+rtl
rtl/hkp_pkg.sv
rtl/hkp_byte_ram.sv
rtl/hkp_layout.sv
rtl/hkp_emitter.sv
rtl/hid_keyboard_report_parser.sv
tb/sv/hid_keyboard_report_parser_tb.sv
